// File: rtl/core/seeded_mum_hash64_stream_assert.svh
// Assertion macros for the seeded multiply-fold hash block.
`ifndef SEEDED_MUM_HASH64_STREAM_ASSERT_SVH
`define SEEDED_MUM_HASH64_STREAM_ASSERT_SVH
`ifndef SYNTH
`define SMH_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SMH_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SMH_ASSERT_IMP(label, clk, rst_n, a, c)
`define SMH_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/smh_pkg.sv
// ----------------------------------------------------------------------------
// smh_pkg
// Constants, types and fold helpers shared by the hash front and back parts.
// ----------------------------------------------------------------------------
package smh_pkg;
	localparam int unsigned BLOCK_BYTES = 32;
	localparam logic [63:0] K0 = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] K1 = 64'h6c62272e07bb0142;
	localparam logic [63:0] K2 = 64'h94d049bb133111eb;
	localparam logic [63:0] K3 = 64'hbf58476d1ce4e5b9;

	// Job codes for the back part.
	typedef enum logic [0:0] {
		JOB_BLOCK = 1'b0,
		JOB_FINISH = 1'b1
	} job_kind_t;

	// One request from the front part to the back part: a full block or
	// the end of the message with its tail. A block whose last byte also
	// ends the message carries ends_msg so the back part finishes after it.
	typedef struct packed {
		job_kind_t kind;
		logic ends_msg;
		logic [8*BLOCK_BYTES-1:0] bytes;
		logic [4:0] fill;
		logic [63:0] length;
		logic [63:0] seed;
	} job_t;

	// Back part sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_STEP,
		ST_DONE
	} back_state_t;

	// Fold of a 128-bit product: high half XOR low half.
	function automatic logic [63:0] fold128(input logic [127:0] p);
		fold128 = p[127:64] ^ p[63:0];
	endfunction
endpackage

// File: rtl/core/smh_front.sv
// ----------------------------------------------------------------------------
// smh_front
// Collects message bytes into 32-byte blocks and issues block and finish
// requests to the job queue.
// ----------------------------------------------------------------------------
module smh_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] data_byte,
	input  logic byte_valid,
	input  logic last,
	input  logic in_valid,
	output logic in_ready,
	input  logic [63:0] seed_q_in,
	input  logic restart,
	output logic job_valid,
	output smh_pkg::job_t job,
	input  logic job_full
);
	import smh_pkg::*;

	localparam int unsigned FW = $clog2(BLOCK_BYTES);

	logic [7:0] buf_q [BLOCK_BYTES];
	logic [FW-1:0] fill_q;
	logic [63:0] len_q;
	logic [255:0] bytes_now;
	logic accept;
	logic blk_full;

	assign in_ready = !job_full;
	assign accept = in_valid && in_ready;
	assign blk_full = byte_valid && (fill_q == FW'(BLOCK_BYTES - 1));

	// Gather buffered bytes plus the incoming byte into one block image.
	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (byte_valid && (fill_q == FW'(i))) begin
				bytes_now[8*i +: 8] = data_byte;
			end else begin
				bytes_now[8*i +: 8] = buf_q[i];
			end
		end
	end

	// A request goes out on a full block or on the last item.
	always_comb begin
		job_valid = accept && (blk_full || last);
		job.kind = blk_full ? JOB_BLOCK : JOB_FINISH;
		job.ends_msg = last;
		job.bytes = bytes_now;
		job.fill = byte_valid ? 5'(fill_q + 1'b1) : 5'(fill_q);
		job.length = byte_valid ? len_q + 64'd1 : len_q;
		job.seed = seed_q_in;
	end

	// Byte buffer stores without reset.
	always_ff @(posedge clk) begin
		if (accept && byte_valid) begin
			buf_q[fill_q] <= data_byte;
		end
	end

	// Fill and length counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
		end else if (restart) begin
			fill_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			if (last) begin
				fill_q <= '0;
				len_q <= '0;
			end else if (byte_valid) begin
				fill_q <= fill_q + 1'b1;
				len_q <= len_q + 64'd1;
			end
		end
	end
endmodule

// File: rtl/core/smh_queue.sv
// ----------------------------------------------------------------------------
// smh_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module smh_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  smh_pkg::job_t wr_job,
	output logic full,
	output logic rd_valid,
	output smh_pkg::job_t rd_job,
	input  logic rd_en
);
	import smh_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	`include "seeded_mum_hash64_stream_assert.svh"
	`SMH_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !wr_en)
	`SMH_ASSERT_IMP(a_no_underflow, clk, arst_n, !rd_valid, !rd_en)
	`SMH_ASSERT_NXT(a_cnt_move, clk, arst_n, wr_en && !rd_en, cnt_q == $past(cnt_q) + 2'd1)
endmodule

// File: rtl/core/smh_back.sv
// ----------------------------------------------------------------------------
// smh_back
// Lane state and a shared 32x32 multiplier that builds each 64x64 product
// from 32x32 partial products and runs block absorption, tail mix and
// finalization as a sequence of multiply steps.
// ----------------------------------------------------------------------------
module smh_back (
	input  logic clk,
	input  logic arst_n,
	input  logic restart,
	input  logic [63:0] seed_val,
	input  logic job_valid,
	input  smh_pkg::job_t job,
	output logic job_take,
	output logic res_valid,
	output logic [63:0] res_value,
	input  logic res_ready
);
	import smh_pkg::*;

	back_state_t st_q, st_d;
	logic [63:0] la_q, lb_q, lc_q, ld_q;
	logic [3:0] step_q;
	logic [1:0] pp_q;
	logic [63:0] acc_q, h_q, t_q;
	logic [63:0] ma_q, mb_q;
	logic [127:0] prod_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] part;
	logic [127:0] part_sh;
	logic [63:0] fold;
	logic [63:0] op_a, op_b;
	logic [3:0] nstep;
	logic last_step;
	logic busy_job;
	logic [255:0] by;
	logic [4:0] fl;
	logic [4:0] pos;
	logic [4:0] lft;
	logic [63:0] w_lo, w_hi;
	logic [63:0] tail4;
	logic [63:0] tail3;

	assign by = job.bytes;
	assign fl = job.fill;
	assign fold = fold128(prod_q);

	function automatic logic [7:0] byte_at(input logic [255:0] b, input logic [4:0] p);
		byte_at = b[8*p +: 8];
	endfunction

	function automatic logic [63:0] word_at(input logic [255:0] b, input logic [4:0] p);
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			w[8*i +: 8] = byte_at(b, 5'(p + 5'(i)));
		end
		word_at = w;
	endfunction

	// Tail position after the 16 and 8 byte rounds.
	always_comb begin
		pos = {fl[4], fl[3], 3'b000};
		lft = {2'b00, fl[2:0]};
		w_lo = word_at(by, pos);
		w_hi = word_at(by, 5'(pos + lft - 5'd4));
		tail4 = {w_hi[31:0], w_lo[31:0]};
		if (fl[2]) begin
			pos = 5'(pos + 5'd4);
			lft = 5'(lft - 5'd4);
		end
		tail3 = {40'h0, byte_at(by, 5'(pos + lft - 5'd1)),
			byte_at(by, 5'(pos + (lft >> 1))), byte_at(by, pos)};
	end

	// Step operands. Block steps 0..3; finish steps 4..13.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			4'd0: begin op_a = la_q ^ word_at(by, 5'd0); op_b = K1; end
			4'd1: begin op_a = lb_q ^ word_at(by, 5'd8); op_b = K2; end
			4'd2: begin op_a = lc_q ^ word_at(by, 5'd16); op_b = K3; end
			4'd3: begin op_a = ld_q ^ word_at(by, 5'd24); op_b = K0; end
			4'd4: begin op_a = acc_q ^ word_at(by, 5'd0); op_b = K2; end
			4'd5: begin op_a = acc_q ^ word_at(by, 5'd8); op_b = K3; end
			4'd6: begin op_a = acc_q ^ word_at(by, {fl[4], 4'b0000}); op_b = K0; end
			4'd7: begin op_a = acc_q ^ tail4; op_b = K1; end
			4'd8: begin op_a = acc_q ^ tail3; op_b = K2; end
			4'd9: begin op_a = la_q ^ K0; op_b = lb_q ^ K1; end
			4'd10: begin op_a = lc_q ^ K0; op_b = ld_q ^ K1; end
			4'd11: begin op_a = h_q ^ t_q; op_b = K3; end
			4'd12: begin op_a = acc_q ^ (acc_q >> 33); op_b = K0; end
			4'd13: begin op_a = acc_q ^ (acc_q >> 29); op_b = K2; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// One 32x32 partial product per cycle, placed at its weight.
	always_comb begin
		mul_a = pp_q[1] ? ma_q[63:32] : ma_q[31:0];
		mul_b = pp_q[0] ? mb_q[63:32] : mb_q[31:0];
		part = 64'(mul_a) * 64'(mul_b);
		unique case (pp_q)
			2'd0: part_sh = {64'd0, part};
			2'd1: part_sh = {32'd0, part, 32'd0};
			2'd2: part_sh = {32'd0, part, 32'd0};
			2'd3: part_sh = {part, 64'd0};
		endcase
	end

	// Next step, skipping tail rounds that the fill does not need. A block
	// that also ends the message goes straight on to the finalization.
	always_comb begin
		priority if (step_q < 4'd3) nstep = 4'(step_q + 4'd1);
		else if (step_q == 4'd3) nstep = job.ends_msg ? 4'd9 : 4'd0;
		else if (step_q == 4'd4) nstep = 4'd5;
		else if (step_q < 4'd6 && fl[3]) nstep = 4'd6;
		else if (step_q < 4'd7 && fl[2]) nstep = 4'd7;
		else if (step_q < 4'd8 && fl[1:0] != 2'b00) nstep = 4'd8;
		else nstep = (step_q < 4'd9) ? 4'd9 : 4'(step_q + 4'd1);
		last_step = (step_q == 4'd3 && !job.ends_msg) || (step_q == 4'd13);
	end

	// First finish step from the fill.
	function automatic logic [3:0] first_fin(input logic [4:0] f);
		priority if (f[4]) first_fin = 4'd4;
		else if (f[3]) first_fin = 4'd6;
		else if (f[2]) first_fin = 4'd7;
		else if (f[1:0] != 2'b00) first_fin = 4'd8;
		else first_fin = 4'd9;
	endfunction

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (job_valid) st_d = ST_MUL;
			ST_MUL: st_d = ST_ACC;
			ST_ACC: if (pp_q == 2'd3) st_d = ST_STEP;
			ST_STEP: begin
				if (last_step) st_d = (step_q == 4'd13) ? ST_DONE : ST_IDLE;
				else st_d = ST_MUL;
			end
			ST_DONE: if (res_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy_job = (st_q != ST_IDLE);
		job_take = (st_q == ST_STEP && step_q == 4'd3 && !job.ends_msg)
			|| (st_q == ST_DONE && res_ready);
		res_valid = (st_q == ST_DONE);
		res_value = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= 4'd0;
			pp_q <= 2'd0;
			la_q <= K0;
			lb_q <= K1;
			lc_q <= K2;
			ld_q <= K3;
		end else begin
			st_q <= st_d;
			if (st_q == ST_MUL) begin
				pp_q <= 2'd0;
			end else if (st_q == ST_ACC) begin
				pp_q <= pp_q + 2'd1;
			end
			if (restart) begin
				la_q <= seed_val ^ K0;
				lb_q <= seed_val ^ K1;
				lc_q <= seed_val ^ K2;
				ld_q <= seed_val ^ K3;
			end
			if (st_q == ST_IDLE && job_valid) begin
				step_q <= (job.kind == JOB_BLOCK) ? 4'd0 : first_fin(fl);
			end
			if (st_q == ST_STEP) begin
				step_q <= nstep;
				unique case (step_q)
					4'd0: la_q <= fold;
					4'd1: lb_q <= fold;
					4'd2: lc_q <= fold;
					4'd3: ld_q <= fold;
					default: ;
				endcase
			end
			if (st_q == ST_DONE && res_ready) begin
				la_q <= job.seed ^ K0;
				lb_q <= job.seed ^ K1;
				lc_q <= job.seed ^ K2;
				ld_q <= job.seed ^ K3;
			end
		end
	end

	// Datapath registers: operand latch, accumulation of the partial products,
	// then fold and accumulate.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && job_valid && job.kind == JOB_FINISH) begin
			acc_q <= la_q ^ lb_q ^ lc_q ^ ld_q;
		end
		if (st_q == ST_MUL) begin
			ma_q <= op_a;
			mb_q <= op_b;
			prod_q <= '0;
		end
		if (st_q == ST_ACC) begin
			prod_q <= prod_q + part_sh;
		end
		if (st_q == ST_STEP) begin
			unique case (step_q)
				4'd8: acc_q <= fold;
				4'd9: h_q <= fold;
				4'd10: h_q <= h_q ^ fold;
				4'd11: acc_q <= fold;
				4'd12: acc_q <= prod_q[63:0];
				4'd13: acc_q <= prod_q[63:0] ^ (prod_q[63:0] >> 32);
				default: if (step_q >= 4'd4) acc_q <= fold;
			endcase
			// After a final block the tail is empty, so the mix input is the
			// XOR of the updated lanes.
			if (nstep == 4'd9 && step_q < 4'd9) begin
				t_q <= ((step_q == 4'd3) ? (la_q ^ lb_q ^ lc_q ^ fold) : fold)
					^ job.length;
			end
		end
		if (st_q == ST_IDLE && job_valid && job.kind == JOB_FINISH
			&& first_fin(fl) == 4'd9) begin
			t_q <= (la_q ^ lb_q ^ lc_q ^ ld_q) ^ job.length;
		end
	end

	`include "seeded_mum_hash64_stream_assert.svh"
	`SMH_ASSERT_IMP(a_res_only_done, clk, arst_n, res_valid, st_q == ST_DONE && job_valid)
	`SMH_ASSERT_IMP(a_take_valid, clk, arst_n, job_take, job_valid)
	`SMH_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_value))
	`SMH_ASSERT_IMP(a_busy_job, clk, arst_n, busy_job, job_valid)
endmodule

// File: rtl/core/seeded_mum_hash64_stream.sv
// A message enters one byte per request, one request per cycle while the
// two-entry job queue has room. Each full 32-byte block and each end of
// message becomes one job for the back part, which builds every 64x64
// product on one 32x32 multiplier from partial products; each multiply
// step passes through the ST_MUL, ST_ACC and ST_STEP states. A finish job
// also waits for its result to be taken. Sustained rate is one byte per
// cycle on long messages while the job queue has room. Writing the seed
// starts a new message and must only happen while the block is idle.
// ----------------------------------------------------------------------------
// seeded_mum_hash64_stream
// Streaming seeded 64-bit multiply-fold hash, top level.
// ----------------------------------------------------------------------------
module seeded_mum_hash64_stream (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic byte_valid,
	input  logic last,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] hash_value,
	input  logic cfg_we,
	input  logic [63:0] cfg_wdata
);
	import smh_pkg::*;

	logic [63:0] seed_q;
	logic jv, jfull, qv, take;
	job_t jw, jr;

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	smh_front u_front (
		.clk, .arst_n, .data_byte, .byte_valid, .last, .in_valid, .in_ready,
		.seed_q_in(seed_q), .restart(cfg_we), .job_valid(jv), .job(jw),
		.job_full(jfull)
	);

	smh_queue u_queue (
		.clk, .arst_n, .wr_en(jv), .wr_job(jw), .full(jfull),
		.rd_valid(qv), .rd_job(jr), .rd_en(take)
	);

	smh_back u_back (
		.clk, .arst_n, .restart(cfg_we), .seed_val(cfg_wdata),
		.job_valid(qv), .job(jr), .job_take(take),
		.res_valid(out_valid), .res_value(hash_value), .res_ready(out_ready)
	);
endmodule

// File: dv/seeded_mum_hash64_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_mum_hash64_stream_checker
// Watches the byte and hash channels, computes the expected hash of every
// finished message and compares it with what the block returns.
// ----------------------------------------------------------------------------
module seeded_mum_hash64_stream_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [7:0] data_byte,
	input  logic byte_valid,
	input  logic last,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [63:0] hash_value,
	input  logic cfg_we,
	input  logic [63:0] cfg_wdata,
	output int fail_count,
	output int hashes_pending
);
	import smh_pkg::*;

	logic [63:0] cur_seed;
	logic [63:0] lane [4];
	logic [63:0] msg_len;
	logic [7:0] blk [32];
	int fill;
	logic [63:0] hash_queue [$];

	// Full 128-bit product folded as high XOR low.
	function automatic logic [63:0] mul_fold(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[127:64] ^ p[63:0];
	endfunction

	// Little-endian load of n buffered bytes starting at pos.
	function automatic logic [63:0] load_le(input int pos, input int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v |= 64'(blk[(pos + i) & 31]) << (8 * i);
		return v;
	endfunction

	function automatic void restart_message();
		lane[0] = cur_seed ^ K0;
		lane[1] = cur_seed ^ K1;
		lane[2] = cur_seed ^ K2;
		lane[3] = cur_seed ^ K3;
		msg_len = '0;
		fill = 0;
	endfunction

	function automatic logic [63:0] final_hash();
		logic [63:0] acc, t, h, v;
		int pos, left;
		acc = lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
		pos = 0;
		left = fill;
		if (left >= 16) begin
			acc = mul_fold(acc ^ load_le(pos, 8), K2);
			acc = mul_fold(acc ^ load_le(pos + 8, 8), K3);
			pos += 16;
			left -= 16;
		end
		if (left >= 8) begin
			acc = mul_fold(acc ^ load_le(pos, 8), K0);
			pos += 8;
			left -= 8;
		end
		if (left >= 4) begin
			acc ^= load_le(pos, 4) | (load_le(pos + left - 4, 4) << 32);
			acc = mul_fold(acc, K1);
			pos += 4;
			left -= 4;
		end
		if (left > 0) begin
			v = load_le(pos, 1) | (load_le(pos + (left >> 1), 1) << 8)
				| (load_le(pos + left - 1, 1) << 16);
			acc = mul_fold(acc ^ v, K2);
		end
		t = acc ^ msg_len;
		h = mul_fold(lane[0] ^ K0, lane[1] ^ K1) ^ mul_fold(lane[2] ^ K0, lane[3] ^ K1);
		h = mul_fold(h ^ t, K3);
		h ^= h >> 33;
		h *= K0;
		h ^= h >> 29;
		h *= K2;
		h ^= h >> 32;
		return h;
	endfunction

	assign hashes_pending = hash_queue.size();

	// Predict on every accepted byte request and check every accepted hash.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			fail_count = 0;
			cur_seed = '0;
			for (int i = 0; i < 32; i++)
				blk[i] = '0;
			hash_queue.delete();
			restart_message();
		end else begin
			if (cfg_we) begin
				cur_seed = cfg_wdata;
				restart_message();
			end
			if (out_valid && out_ready) begin
				if (hash_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected hash %h", hash_value);
				end else begin
					want = hash_queue.pop_front();
					if (want !== hash_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("hash mismatch: expected %h actual %h", want, hash_value);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (byte_valid) begin
					blk[fill] = data_byte;
					fill++;
					msg_len++;
					if (fill == 32) begin
						lane[0] = mul_fold(lane[0] ^ load_le(0, 8), K1);
						lane[1] = mul_fold(lane[1] ^ load_le(8, 8), K2);
						lane[2] = mul_fold(lane[2] ^ load_le(16, 8), K3);
						lane[3] = mul_fold(lane[3] ^ load_le(24, 8), K0);
						fill = 0;
					end
				end
				if (last) begin
					hash_queue.push_back(final_hash());
					restart_message();
				end
			end
		end
	end
endmodule

// File: dv/seeded_mum_hash64_stream_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_mum_hash64_stream_test
// Drives byte messages of many lengths under several seeds with random
// stalls on both channels; the checker predicts and compares each hash.
// ----------------------------------------------------------------------------
module seeded_mum_hash64_stream_test;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic byte_valid;
	logic last;
	logic out_valid;
	logic out_ready;
	logic [63:0] hash_value;
	logic cfg_we;
	logic [63:0] cfg_wdata;
	int fail_count;
	int hashes_pending;
	int cycle_count;
	bit calm;

	seeded_mum_hash64_stream u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_valid(byte_valid), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	seeded_mum_hash64_stream_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .byte_valid(byte_valid), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .hashes_pending(hashes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver side: ready drops in random bursts except in the calm tail.
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Present one byte request and hold it until accepted.
	task automatic send_byte(input logic [7:0] b, input logic bv, input logic lst);
		int gap;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_valid <= bv;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// One message of len bytes; some noise requests with no byte mixed in.
	task automatic send_message(input int len, input bit noisy, input bit empty_end);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_byte(8'($urandom), 1'b0, 1'b0);
			send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
		end
		if (empty_end || len == 0)
			send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	// Wait until every hash is back and the back part has gone quiet, then write the seed.
	task automatic drain_and_write(input logic [63:0] s);
		in_valid <= 1'b0;
		while (hashes_pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int len;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_valid = 1'b0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty message, each tail class, a full block, byte extremes.
		send_message(0, 0, 1);
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hff, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h55, 1'b1, 1'b0);
		send_byte(8'haa, 1'b1, 1'b1);
		send_message(4, 0, 0);
		send_message(8, 0, 1);
		send_message(16, 0, 0);
		drain_and_write(64'hffff_ffff_ffff_ffff);
		send_message(31, 0, 0);
		send_message(32, 0, 0);
		drain_and_write(64'h0);
		send_message(33, 0, 1);

		// Random messages under several seeds, short lengths favored.
		sent = 120;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: drain_and_write({$urandom, $urandom});
				1: drain_and_write(64'hffff_ffff_ffff_ffff);
				2: drain_and_write({$urandom, $urandom});
				3: drain_and_write(64'h0);
				default: drain_and_write({$urandom, $urandom});
			endcase
			if (phase == 4)
				calm = 1'b1;
			while (sent < (phase + 1) * 290 + 120) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 100)
					: $urandom_range(0, 40);
				send_message(len, 1, $urandom_range(0, 3) == 0);
				sent += len + 1;
			end
		end

		in_valid <= 1'b0;
		while (hashes_pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
